@@ hw/rtl/qdv_pkg.sv @@
// Shared types, constants and lookup functions for the quadrature decoder.
`timescale 1ns / 1ps
`default_nettype none
package qdv_pkg;

  localparam int unsigned PinsW    = 2;
  localparam int unsigned TickW    = 16;
  localparam int unsigned SpeedW   = 10;
  localparam int unsigned VelW     = 11;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned DivStepW = 4;

  localparam logic [DivStepW-1:0] DivLastStep = DivStepW'(SpeedW - 1);
  localparam logic [TickW-1:0]    TickMax     = '1;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegTicksPerSec = 2'd0;
  localparam logic [CfgAddrW-1:0] RegIdleTimeout = 2'd1;
  localparam logic [CfgAddrW-1:0] RegSlowLimit   = 2'd2;
  localparam logic [CfgAddrW-1:0] RegMedLimit    = 2'd3;

  // direction codes
  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirCw   = 2'd1;
  localparam logic [1:0] DirCcw  = 2'd2;

  // speed class codes
  localparam logic [1:0] ClsStill  = 2'd0;
  localparam logic [1:0] ClsSlow   = 2'd1;
  localparam logic [1:0] ClsMedium = 2'd2;
  localparam logic [1:0] ClsFast   = 2'd3;

  // moves out of phase 3 into phase 1 or 2 trigger a speed update
  localparam logic [3:0] MoveSpeedA = 4'hD;
  localparam logic [3:0] MoveSpeedB = 4'hE;

  localparam logic [15:0] GrayMoveOk = 16'b0110_1001_1001_0110;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic gray_move_ok(input logic [3:0] move);
    return GrayMoveOk[move];
  endfunction

  function automatic logic [1:0] turn_direction(input logic [1:0] last,
                                                input logic [1:0] now);
    logic [3:0] pair;
    logic [1:0] dir;
    pair = {last, now};
    case (pair)
      4'hB, 4'hD, 4'h4, 4'h2: dir = DirCw;
      4'h7, 4'hE, 4'h8, 4'h1: dir = DirCcw;
      default:                dir = DirNone;
    endcase
    return dir;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/qdv_div.sv @@
// Bit-serial restoring divider: 10-bit dividend by 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qdv_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [qdv_pkg::SpeedW-1:0] dividend_i,
  input  wire logic [qdv_pkg::TickW-1:0]  divisor_i,
  output qdv_pkg::div_stat_t              stat_o,
  output logic [qdv_pkg::SpeedW-1:0]      quot_o
);
  import qdv_pkg::*;

  logic                busy_q, busy_d;
  logic [DivStepW-1:0] cnt_q, cnt_d;
  logic [TickW-1:0]    rem_q, rem_d;
  logic [SpeedW-1:0]   quo_q, quo_d;
  logic [TickW-1:0]    dvs_q, dvs_d;

  logic [TickW:0]   rem_sh;
  logic [TickW+1:0] diff;
  logic             fit;

  assign rem_sh = {rem_q, quo_q[SpeedW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign fit    = ~diff[TickW+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits always hold it
      rem_d = fit ? diff[TickW-1:0] : rem_sh[TickW-1:0];
      quo_d = {quo_q[SpeedW-2:0], fit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivLastStep) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == DivLastStep);
  assign quot_o      = {quo_q[SpeedW-2:0], fit};

`ifndef NO_ASSERTIONS
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_o.done && !start_i) |=> !busy_q)
    else $error("divider still busy after last step");
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q != DivLastStep) |=> (busy_q && cnt_q == $past(cnt_q) + 1'b1))
    else $error("divider step counter skipped");
  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> ({6'd0, quot_o} <= dvs_q * 16'd0 + {6'd0, 10'h3FF}))
    else $error("quotient out of range");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/quadrature_decoder_velocity.sv @@
// Top level: quadrature decoder with tick-count velocity estimate and speed class.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted word is one timer tick carrying the two sampled encoder lines.
// A tick without a speed update goes from the idle state to the output step,
// which registers its result into the output register. A valid move out of
// phase 3 into phase 1 or 2 runs the bit-serial divider (ticks_per_second /
// tick count, one quotient bit a cycle) first, then goes to the output step.
// The input is ready only while the sequencer is idle, so a new tick is not
// taken before the last one is through; a finished result waits in the output
// register while the next tick is taken, and a result still held there stalls
// the sequencer in its output step for as long as the output is not taken.
// Configuration writes land at once and should be made while no tick is in work.
module quadrature_decoder_velocity (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [1:0] pins, [7:2] zero
  input  wire logic [qdv_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [1:0] phase, [3:2] direction, [14:4] velocity, [16:15] speed_class, [23:17] zero
  output logic [qdv_pkg::OutDataW-1:0]       m_axis_tdata_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [qdv_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [qdv_pkg::CfgDataW-1:0]  cfg_data_i
);
  import qdv_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  logic [SpeedW-1:0] tps_q;
  logic [TickW-1:0]  idle_q;
  logic [SpeedW-1:0] slow_q;
  logic [SpeedW-1:0] med_q;

  logic [1:0]        cur_q, cur_d;
  logic [1:0]        prev_q, prev_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [SpeedW-1:0] speed_q, speed_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic              accept;
  logic [1:0]        pins;
  logic [TickW-1:0]  tick_inc;
  logic [3:0]        move;
  logic              move_ok;
  logic              speed_move;
  logic              div_start;
  div_stat_t         div_stat;
  logic [SpeedW-1:0] div_quot;

  logic [1:0]        dir;
  logic [SpeedW-1:0] mag;
  logic [VelW-1:0]   vel;
  logic [1:0]        cls;
  logic              out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pins            = s_axis_tdata_i[PinsW-1:0];
  assign tick_inc        = (tick_q == TickMax) ? tick_q : tick_q + 1'b1;
  assign move            = {cur_q, pins};
  assign move_ok         = gray_move_ok(move);
  assign speed_move      = move_ok && (move == MoveSpeedA || move == MoveSpeedB);
  assign div_start       = accept && speed_move;

  qdv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tps_q),
    .divisor_i  (tick_inc),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // result fields from the updated state
  assign dir = turn_direction(prev_q, cur_q);
  assign mag = (dir == DirNone) ? '0 : speed_q;
  assign vel = (dir == DirCcw) ? (VelW'(0) - {1'b0, mag}) : {1'b0, mag};

  always_comb begin
    if (mag == '0) begin
      cls = ClsStill;
    end else if (mag <= slow_q) begin
      cls = ClsSlow;
    end else if (mag <= med_q) begin
      cls = ClsMedium;
    end else begin
      cls = ClsFast;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    tick_d      = tick_q;
    speed_d     = speed_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          tick_d = tick_inc;
          if (move_ok) begin
            prev_d = cur_q;
            cur_d  = pins;
          end else if (tick_inc >= idle_q) begin
            speed_d = '0;
          end
          state_d = speed_move ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          speed_d = div_quot;
          tick_d  = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {{(OutDataW - 17){1'b0}}, cls, vel, dir, cur_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      prev_q      <= '0;
      tick_q      <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
      tps_q       <= SpeedW'(1000);
      idle_q      <= TickW'(500);
      slow_q      <= SpeedW'(15);
      med_q       <= SpeedW'(50);
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      tick_q      <= tick_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          RegTicksPerSec: tps_q  <= cfg_data_i[SpeedW-1:0];
          RegIdleTimeout: idle_q <= cfg_data_i[TickW-1:0];
          RegSlowLimit:   slow_q <= cfg_data_i[SpeedW-1:0];
          RegMedLimit:    med_q  <= cfg_data_i[SpeedW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == S_DIV))
    else $error("divider running outside division state");
  a_tick_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_stat.done) |=> (tick_q == '0 && state_q == S_OUT))
    else $error("tick count not cleared after speed update");
  a_div_state_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> div_stat.busy)
    else $error("division state without running divider");
  a_vel_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[3:2] == DirNone) |-> (m_axis_tdata_o[16:4] == '0))
    else $error("nonzero velocity or class without direction");
`endif
endmodule
`default_nettype wire
